// ----- hdl/rsvp_pkg.sv -----
// Shared types and constants for the replay stream validating parser.
// Holds the channel payload structs, status codes and format constants.
// No dependencies.
package rsvp_pkg;

   localparam int unsigned POS_W     = 38;
   localparam int unsigned OFF_W     = 5;
   localparam int unsigned Q_DEPTH   = 4;
   localparam int unsigned Q_PTR_W   = 2;
   localparam int unsigned Q_CNT_W   = 3;

   localparam logic [POS_W-1:0] POS_MAX       = {POS_W{1'b1}};
   localparam logic [OFF_W-1:0] OFF_TICK_END  = 5'd3;
   localparam logic [OFF_W-1:0] OFF_KIND      = 5'd4;
   localparam logic [OFF_W-1:0] OFF_CODE_END  = 5'd11;
   localparam logic [OFF_W-1:0] OFF_X_END     = 5'd15;
   localparam logic [OFF_W-1:0] OFF_REC_END   = 5'd19;
   localparam logic [3:0]       HDR_VERSION   = 4'd7;
   localparam logic [3:0]       HDR_COUNT     = 4'd11;
   localparam logic [3:0]       HDR_SPAN      = 4'd15;
   localparam logic [31:0]      FORMAT_VERSION = 32'd1;
   localparam logic [7:0]       KIND_MAX      = 8'd5;

   localparam logic ITEM_EVENT  = 1'b0;
   localparam logic ITEM_STATUS = 1'b1;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_SHORT   = 3'd1;
   localparam logic [2:0] ST_MAGIC   = 3'd2;
   localparam logic [2:0] ST_VERSION = 3'd3;
   localparam logic [2:0] ST_SIZE    = 3'd4;
   localparam logic [2:0] ST_TYPE    = 3'd5;
   localparam logic [2:0] ST_ORDER   = 3'd6;
   localparam logic [2:0] ST_SPAN    = 3'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic        item_kind;
      logic [31:0] event_tick;
      logic [2:0]  event_kind;
      logic [31:0] event_code;
      logic [31:0] pos_x_bits;
      logic [31:0] pos_y_bits;
      logic [2:0]  status;
      logic [31:0] tick_total;
      logic        run_last;
   } rsp_type;

   // Results caused by one byte: none, one, or an event followed by a status.
   typedef struct packed {
      logic    has0;
      logic    has1;
      rsp_type res0;
      rsp_type res1;
   } pair_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h4E;
         2'd1:    val = 8'h46;
         2'd2:    val = 8'h52;
         default: val = 8'h50;
      endcase
      return val;
   endfunction

endpackage

// ----- hdl/rsvp_parse.sv -----
// Byte parser: header checks, record assembly and end-of-stream status.
// Produces the results of one byte combinationally from its state registers.
// Depends on rsvp_pkg.
module rsvp_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_fire,
   input  rsvp_pkg::req_type in_req,
   output rsvp_pkg::pair_type out_pair
);
   import rsvp_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0]      gather_ff, gather_in;
   logic             magic_bad_ff, magic_bad_in;
   logic             version_bad_ff, version_bad_in;
   logic [31:0]      count_ff, count_in;
   logic [31:0]      span_ff, span_in;
   logic [OFF_W-1:0] offset_ff, offset_in;
   logic [31:0]      tick_ff, tick_in;
   logic [7:0]       kind_ff, kind_in;
   logic [31:0]      code_ff, code_in;
   logic [31:0]      x_ff, x_in;
   logic [31:0]      prev_ff, prev_in;
   logic [2:0]       fre_ff, fre_in;

   logic             is_hdr;
   logic             ev_hit;
   logic [POS_W:0]   size_w;
   logic [POS_W:0]   want_w;
   logic [2:0]       st_code;
   logic [31:0]      total;
   rsp_type          ev_res;
   rsp_type          st_res;

   always_comb begin
      gather_in      = {in_req.data_byte, gather_ff[31:8]};
      pos_in         = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
      magic_bad_in   = magic_bad_ff;
      version_bad_in = version_bad_ff;
      count_in       = count_ff;
      span_in        = span_ff;
      offset_in      = offset_ff;
      tick_in        = tick_ff;
      kind_in        = kind_ff;
      code_in        = code_ff;
      x_in           = x_ff;
      prev_in        = prev_ff;
      fre_in         = fre_ff;
      is_hdr         = (pos_ff[POS_W-1:4] == '0);
      ev_hit         = 1'b0;

      if (is_hdr) begin
         if (pos_ff[3:2] == 2'd0) begin
            if (in_req.data_byte != magic_byte(pos_ff[1:0])) magic_bad_in = 1'b1;
         end else if (pos_ff[3:0] == HDR_VERSION) begin
            if (gather_in != FORMAT_VERSION) version_bad_in = 1'b1;
         end else if (pos_ff[3:0] == HDR_COUNT) begin
            count_in = gather_in;
         end else if (pos_ff[3:0] == HDR_SPAN) begin
            span_in = gather_in;
         end
      end else begin
         case (offset_ff)
            OFF_TICK_END: tick_in = gather_in;
            OFF_KIND:     kind_in = in_req.data_byte;
            OFF_CODE_END: code_in = gather_in;
            OFF_X_END:    x_in    = gather_in;
            OFF_REC_END: begin
               ev_hit = 1'b1;
               if (fre_ff == ST_OK) begin
                  if (kind_ff > KIND_MAX)     fre_in = ST_TYPE;
                  else if (tick_ff < prev_ff) fre_in = ST_ORDER;
               end
               prev_in = tick_ff;
            end
            default: ;
         endcase
         offset_in = (offset_ff >= OFF_REC_END) ? '0 : offset_ff + 1'b1;
      end

      // end-of-stream status, from the state after this byte
      size_w = {1'b0, pos_ff} + 1'b1;
      want_w = ({7'd0, count_in} << 4) + ({7'd0, count_in} << 2) + (POS_W+1)'(16);
      total  = '0;
      if (pos_ff < (POS_W)'(15))         st_code = ST_SHORT;
      else if (magic_bad_in)             st_code = ST_MAGIC;
      else if (version_bad_in)           st_code = ST_VERSION;
      else if (size_w != want_w)         st_code = ST_SIZE;
      else if (fre_in != ST_OK)          st_code = fre_in;
      else if ((count_in != '0) && (span_in < prev_in + 32'd1)) st_code = ST_SPAN;
      else begin
         st_code = ST_OK;
         total   = (count_in != '0) ? span_in : '0;
      end

      ev_res            = '0;
      ev_res.item_kind  = ITEM_EVENT;
      ev_res.event_tick = tick_ff;
      ev_res.event_kind = kind_ff[2:0];
      ev_res.event_code = code_ff;
      ev_res.pos_x_bits = x_ff;
      ev_res.pos_y_bits = gather_in;
      ev_res.run_last   = ~in_req.final_byte;

      st_res            = '0;
      st_res.item_kind  = ITEM_STATUS;
      st_res.status     = st_code;
      st_res.tick_total = total;
      st_res.run_last   = 1'b1;

      out_pair.has0 = in_fire & (ev_hit | in_req.final_byte);
      out_pair.has1 = in_fire & ev_hit & in_req.final_byte;
      out_pair.res0 = ev_hit ? ev_res : st_res;
      out_pair.res1 = st_res;

      // a new stream starts after the final byte
      if (in_req.final_byte) begin
         pos_in         = '0;
         gather_in      = '0;
         magic_bad_in   = 1'b0;
         version_bad_in = 1'b0;
         count_in       = '0;
         span_in        = '0;
         offset_in      = '0;
         tick_in        = '0;
         kind_in        = '0;
         code_in        = '0;
         x_in           = '0;
         prev_in        = '0;
         fre_in         = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         gather_ff      <= '0;
         magic_bad_ff   <= 1'b0;
         version_bad_ff <= 1'b0;
         count_ff       <= '0;
         span_ff        <= '0;
         offset_ff      <= '0;
         tick_ff        <= '0;
         kind_ff        <= '0;
         code_ff        <= '0;
         x_ff           <= '0;
         prev_ff        <= '0;
         fre_ff         <= ST_OK;
      end else if (in_fire) begin
         pos_ff         <= pos_in;
         gather_ff      <= gather_in;
         magic_bad_ff   <= magic_bad_in;
         version_bad_ff <= version_bad_in;
         count_ff       <= count_in;
         span_ff        <= span_in;
         offset_ff      <= offset_in;
         tick_ff        <= tick_in;
         kind_ff        <= kind_in;
         code_ff        <= code_in;
         x_ff           <= x_in;
         prev_ff        <= prev_in;
         fre_ff         <= fre_in;
      end
   end

endmodule

// ----- hdl/rsvp_outq.sv -----
// Result queue: holds result pairs and hands them out one transfer at a time.
// A pair with two results drains over two transfers.
// Depends on rsvp_pkg.
module rsvp_outq (
   input  logic               clock,
   input  logic               reset,
   input  rsvp_pkg::pair_type push_pair,
   output logic               full,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsvp_pkg::rsp_type  rsp_data
);
   import rsvp_pkg::*;

   pair_type             mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   head_ff, head_in;
   logic [Q_PTR_W-1:0]   tail_ff, tail_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 phase_ff, phase_in;
   logic                 push;
   logic                 take;
   logic                 pop;
   pair_type             head_pair;

   always_comb begin
      head_pair = mem_ff[head_ff];
      push      = push_pair.has0;
      full      = (count_ff == Q_CNT_W'(Q_DEPTH));
      rsp_valid = (count_ff != '0);
      rsp_data  = phase_ff ? head_pair.res1 : head_pair.res0;
      take      = rsp_valid & ~rsp_stall;
      pop       = take & (phase_ff | ~head_pair.has1);
      phase_in  = take ? ~pop : phase_ff;
      head_in   = pop ? head_ff + 1'b1 : head_ff;
      tail_in   = push ? tail_ff + 1'b1 : tail_ff;
      count_in  = count_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[tail_ff] <= push_pair;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- hdl/replay_stream_validating_parser.sv -----
// Top level of the replay stream validating parser.
// Input register, byte parser and result queue. Depends on rsvp_pkg,
// rsvp_parse and rsvp_outq.
//
// Usage:
//   req channel: one stream byte per transfer, final_byte set on the last one.
//   rsp channel: one result per transfer. A byte that completes a 20-byte
//   record yields an event; the final byte yields a status after any event
//   it completes. run_last marks the last result of a byte.
//   A byte passes the input register, then its results enter the queue and
//   are offered from it. Throughput: one byte per cycle while the queue has
//   room; a final byte that also ends a record needs two result transfers.
//   The four-entry result queue parts the two sides; req_stall rises only
//   when the queue is full and the input register is occupied.
//   Reset clears the input register, queue and all parser state; after each
//   final byte the parser returns to its reset state for the next stream.
//   While rsp_stall is high the offered result holds steady.
module replay_stream_validating_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rsvp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsvp_pkg::rsp_type rsp_data
);
   import rsvp_pkg::*;

   logic     in_vld_ff, in_vld_in;
   req_type  in_req_ff;
   logic     q_full;
   logic     adv;
   logic     req_take;
   pair_type pair;

   always_comb begin
      adv       = in_vld_ff & ~q_full;
      req_stall = in_vld_ff & q_full;
      req_take  = req_valid & ~req_stall;
      in_vld_in = req_take ? 1'b1 : (adv ? 1'b0 : in_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else       in_vld_ff <= in_vld_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) in_req_ff <= req_data;
   end

   rsvp_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .in_fire  (adv),
      .in_req   (in_req_ff),
      .out_pair (pair)
   );

   rsvp_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push_pair (pair),
      .full      (q_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- dv/tb_replay_stream_validating_parser.sv -----
// Testbench for replay_stream_validating_parser: drives whole replay streams one byte per
// transfer and checks every event and status against an in-bench parser model.
// Depends on rsvp_pkg and the replay_stream_validating_parser RTL.
`timescale 1ns / 1ps

module tb_replay_stream_validating_parser;
   import rsvp_pkg::*;

   localparam int unsigned HEADER_LEN  = 16;
   localparam int unsigned RECORD_LEN  = 20;
   localparam logic [31:0] MAGIC_WORD  = {8'h50, 8'h52, 8'h46, 8'h4E};
   localparam int unsigned PHASE_BYTES = 250;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned TAIL_CYCLES = 8;
   localparam int unsigned LIMIT       = 200000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic        hold_on       = 1'b0;
   int unsigned send_idle_pct = 38;
   int unsigned recv_idle_pct = 84;
   int unsigned cycle_count   = 0;
   int unsigned mismatches    = 0;
   int unsigned bytes_sent    = 0;

   rsp_type    awaited_items[$];
   logic [7:0] stream_buf[$];

   // parser model state
   logic [37:0] at_byte;
   logic [31:0] gather;
   logic        magic_wrong;
   logic        version_wrong;
   logic [31:0] decl_count;
   logic [31:0] decl_span;
   logic [4:0]  rec_off;
   logic [31:0] rec_tick;
   logic [7:0]  rec_kind;
   logic [31:0] rec_code;
   logic [31:0] rec_x;
   logic [31:0] tick_before;
   logic [2:0]  rec_fault;

   replay_stream_validating_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic add_stream_byte(input logic [7:0] b);
      stream_buf.insert(stream_buf.size(), b);
   endtask

   task automatic add_awaited(input rsp_type item);
      awaited_items.insert(awaited_items.size(), item);
   endtask

   task automatic clear_parser_model();
      at_byte       = '0;
      gather        = '0;
      magic_wrong   = 1'b0;
      version_wrong = 1'b0;
      decl_count    = '0;
      decl_span     = '0;
      rec_off       = '0;
      rec_tick      = '0;
      rec_kind      = '0;
      rec_code      = '0;
      rec_x         = '0;
      tick_before   = '0;
      rec_fault     = ST_OK;
   endtask

   task automatic parse_replay_byte(input logic [7:0] b, input logic fin);
      logic [37:0] pos;
      logic [63:0] stream_len;
      logic [63:0] proper_len;
      logic [31:0] next_tick;
      logic        got_event;
      rsp_type     ev;
      rsp_type     st;
      pos       = at_byte;
      got_event = 1'b0;
      ev        = '0;
      st        = '0;
      gather    = {b, gather[31:8]};
      if (pos < HEADER_LEN) begin
         if (pos < 4) begin
            if (b != MAGIC_WORD[8*pos[1:0] +: 8])
               magic_wrong = 1'b1;
         end else if (pos == HDR_VERSION) begin
            if (gather != FORMAT_VERSION)
               version_wrong = 1'b1;
         end else if (pos == HDR_COUNT) begin
            decl_count = gather;
         end else if (pos == HDR_SPAN) begin
            decl_span = gather;
         end
      end else begin
         case (rec_off)
            OFF_TICK_END: rec_tick = gather;
            OFF_KIND:     rec_kind = b;
            OFF_CODE_END: rec_code = gather;
            OFF_X_END:    rec_x    = gather;
            OFF_REC_END: begin
               // type fault outranks order fault within one record
               if (rec_fault == ST_OK) begin
                  if (rec_kind > KIND_MAX)
                     rec_fault = ST_TYPE;
                  else if (rec_tick < tick_before)
                     rec_fault = ST_ORDER;
               end
               tick_before   = rec_tick;
               ev.item_kind  = ITEM_EVENT;
               ev.event_tick = rec_tick;
               ev.event_kind = rec_kind[2:0];
               ev.event_code = rec_code;
               ev.pos_x_bits = rec_x;
               ev.pos_y_bits = gather;
               got_event     = 1'b1;
            end
            default: ;
         endcase
         rec_off = (rec_off == OFF_REC_END) ? '0 : rec_off + 5'd1;
      end
      if (at_byte != '1)
         at_byte = at_byte + 38'd1;
      if (fin) begin
         stream_len   = 64'(pos) + 64'd1;
         proper_len   = 64'(HEADER_LEN) + 64'(decl_count) * 64'(RECORD_LEN);
         next_tick    = tick_before + 32'd1;
         st.item_kind = ITEM_STATUS;
         st.run_last  = 1'b1;
         if (stream_len < HEADER_LEN)
            st.status = ST_SHORT;
         else if (magic_wrong)
            st.status = ST_MAGIC;
         else if (version_wrong)
            st.status = ST_VERSION;
         else if (stream_len != proper_len)
            st.status = ST_SIZE;
         else if (rec_fault != ST_OK)
            st.status = rec_fault;
         else if (decl_count != 0 && decl_span < next_tick)
            st.status = ST_SPAN;
         else begin
            st.status     = ST_OK;
            st.tick_total = (decl_count != 0) ? decl_span : '0;
         end
         if (got_event)
            add_awaited(ev);
         add_awaited(st);
         clear_parser_model();
      end else if (got_event) begin
         ev.run_last = 1'b1;
         add_awaited(ev);
      end
   endtask

   task automatic report_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("cycle %0d: mismatch in%s: expected %h, got %h", cycle_count, what, want, got);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      string   bad;
      bad = "";
      if (awaited_items.size() == 0) begin
         report_mismatch(" unexpected result", '0, got);
         return;
      end
      want = awaited_items.pop_front();
      if (got.item_kind  !== want.item_kind)  bad = {bad, " item_kind"};
      if (got.event_tick !== want.event_tick) bad = {bad, " event_tick"};
      if (got.event_kind !== want.event_kind) bad = {bad, " event_kind"};
      if (got.event_code !== want.event_code) bad = {bad, " event_code"};
      if (got.pos_x_bits !== want.pos_x_bits) bad = {bad, " pos_x_bits"};
      if (got.pos_y_bits !== want.pos_y_bits) bad = {bad, " pos_y_bits"};
      if (got.status     !== want.status)     bad = {bad, " status"};
      if (got.tick_total !== want.tick_total) bad = {bad, " tick_total"};
      if (got.run_last   !== want.run_last)   bad = {bad, " run_last"};
      if (bad != "")
         report_mismatch(bad, want, got);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_result(rsp_data);
      rsp_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      req_type next_req;
      next_req.data_byte  = b;
      next_req.final_byte = fin;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= next_req;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      parse_replay_byte(b, fin);
      bytes_sent++;
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream_buf.size(); i++)
         send_byte(stream_buf[i], i == stream_buf.size() - 1);
      stream_buf.delete();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_items.size() != 0)
         @(posedge clock);
   endtask

   task automatic put_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++)
         add_stream_byte(w[8*i +: 8]);
   endtask

   task automatic put_header(input logic [31:0] magic, input logic [31:0] version,
                             input logic [31:0] count, input logic [31:0] span);
      put_word(magic);
      put_word(version);
      put_word(count);
      put_word(span);
   endtask

   task automatic put_record(input logic [31:0] tick, input logic [7:0] kind,
                             input logic [31:0] code, input logic [31:0] x,
                             input logic [31:0] y);
      put_word(tick);
      add_stream_byte(kind);
      repeat (3) add_stream_byte(8'($urandom()));
      put_word(code);
      put_word(x);
      put_word(y);
   endtask

   task automatic test_short_streams();
      add_stream_byte(8'h00);
      send_stream();
      repeat (15) add_stream_byte(8'hFF);
      send_stream();
      wait_drained();
   endtask

   task automatic test_header_checks();
      put_header({MAGIC_WORD[31:8], 8'h6E}, FORMAT_VERSION, 32'd0, 32'd0);
      send_stream();
      put_header(MAGIC_WORD, 32'd2, 32'd0, 32'd0);
      send_stream();
      put_header(MAGIC_WORD, FORMAT_VERSION, 32'd1, 32'd10);
      send_stream();
      put_header(MAGIC_WORD, FORMAT_VERSION, 32'hFFFF_FFFF, 32'd10);
      send_stream();
      // empty but valid stream: tick total stays zero
      put_header(MAGIC_WORD, FORMAT_VERSION, 32'd0, 32'hFFFF_FFFF);
      send_stream();
      wait_drained();
   endtask

   task automatic test_record_checks();
      put_header(MAGIC_WORD, FORMAT_VERSION, 32'd2, 32'd100);
      put_record(32'd5, 8'hFF, 32'd1, 32'd2, 32'd3);
      put_record(32'd3, 8'd0, 32'd1, 32'd2, 32'd3);
      send_stream();
      put_header(MAGIC_WORD, FORMAT_VERSION, 32'd2, 32'd100);
      put_record(32'd10, 8'd1, 32'd7, 32'd8, 32'd9);
      put_record(32'd9, 8'd5, 32'd7, 32'd8, 32'd9);
      send_stream();
      // last tick at the top of the range: span wraps and zero passes
      put_header(MAGIC_WORD, FORMAT_VERSION, 32'd1, 32'd0);
      put_record(32'hFFFF_FFFF, 8'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_stream();
      put_header(MAGIC_WORD, FORMAT_VERSION, 32'd1, 32'd100);
      put_record(32'd100, 8'd4, 32'd0, 32'h3F80_0000, 32'hBF80_0000);
      send_stream();
      put_header(MAGIC_WORD, FORMAT_VERSION, 32'd2, 32'd1);
      put_record(32'd0, 8'd2, 32'd0, 32'd0, 32'd0);
      put_record(32'd0, 8'd3, 32'd0, 32'd0, 32'd0);
      send_stream();
      put_header(MAGIC_WORD, FORMAT_VERSION, 32'd2, 32'd50);
      put_record(32'd1, 8'd0, 32'd65, 32'd0, 32'd0);
      repeat (7) add_stream_byte(8'($urandom()));
      send_stream();
      put_header(MAGIC_WORD, FORMAT_VERSION, 32'd1, 32'd50);
      put_record(32'd1, 8'd0, 32'd65, 32'd0, 32'd0);
      put_record(32'd2, 8'd1, 32'd65, 32'd0, 32'd0);
      send_stream();
      wait_drained();
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_on <= 1'b0;
         end
      join_none
      put_header(MAGIC_WORD, FORMAT_VERSION, 32'd6, 32'd1000);
      for (int i = 0; i < 6; i++)
         put_record(32'(i * 10), 8'(i), $urandom(), $urandom(), $urandom());
      send_stream();
      repeat (10) begin
         add_stream_byte(8'($urandom()));
         send_stream();
      end
      wait_drained();
   endtask

   task automatic build_random_stream();
      int unsigned shape;
      int unsigned n_rec;
      int unsigned n_decl;
      int unsigned spot;
      logic [31:0] ticks[$];
      logic [7:0]  kinds[$];
      logic [31:0] t;
      logic [31:0] span;
      shape = $urandom_range(99);
      if (shape < 8) begin
         repeat ($urandom_range(1, 40)) add_stream_byte(8'($urandom()));
         return;
      end
      n_rec = ($urandom_range(7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      t     = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(0, 40));
      for (int i = 0; i < n_rec; i++) begin
         ticks.insert(ticks.size(), t);
         kinds.insert(kinds.size(), 8'($urandom_range(0, 5)));
         t = t + 32'($urandom_range(0, 300));
      end
      if (shape >= 96 && n_rec != 0) begin
         spot = $urandom_range(0, n_rec - 1);
         if (spot == 0 || $urandom_range(1) == 1)
            kinds[spot] = 8'($urandom_range(6, 255));
         else
            ticks[spot] = ticks[spot - 1] - 32'($urandom_range(1, 50));
      end
      span = $urandom();
      if (n_rec != 0 && $urandom_range(9) != 0)
         span = ticks[n_rec - 1] + 32'($urandom_range(0, 8));
      n_decl = n_rec;
      if (shape >= 88 && shape < 96)
         n_decl = ($urandom_range(1) == 1) ? n_rec + 1 : n_rec - 1;
      put_header(MAGIC_WORD, FORMAT_VERSION, 32'(n_decl), span);
      for (int i = 0; i < n_rec; i++)
         put_record(ticks[i], kinds[i], $urandom(), $urandom(), $urandom());
      if (shape >= 78 && shape < 84) begin
         spot = $urandom_range(0, stream_buf.size() - 1);
         stream_buf[spot] = stream_buf[spot] ^ (8'd1 << $urandom_range(7));
      end else if (shape >= 84 && shape < 88) begin
         spot = $urandom_range(1, stream_buf.size() - 1);
         while (stream_buf.size() > spot)
            void'(stream_buf.pop_back());
      end
   endtask

   task automatic test_random_streams(input int unsigned target);
      int unsigned start;
      start = bytes_sent;
      while (bytes_sent - start < target) begin
         build_random_stream();
         send_stream();
      end
      wait_drained();
   endtask

   initial begin
      clear_parser_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_short_streams();
      test_header_checks();
      test_record_checks();
      test_backpressure();
      test_random_streams(PHASE_BYTES);
      send_idle_pct = 84;
      recv_idle_pct = 38;
      test_random_streams(PHASE_BYTES);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_streams(PHASE_BYTES);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_items.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/rsvp_pkg.sv
hdl/rsvp_parse.sv
hdl/rsvp_outq.sv
hdl/replay_stream_validating_parser.sv
dv/tb_replay_stream_validating_parser.sv
